### rtl/rm2e_pkg.sv
package rm2e_pkg;

   localparam int DATA_W = 16;
   localparam int CW = 28;
   localparam int ZW = 26;
   localparam int THR_W = 15;
   localparam int PRE_SHIFT = 8;
   localparam int ANG_180 = 5898240;
   localparam int OUT_LIMIT = 23040;
   localparam int INV_W = 17;
   localparam int TAB_LEN = 24;

   localparam int ATAN_TAB [TAB_LEN] = '{
      1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
      7334, 3667, 1833, 917, 458, 229, 115, 57,
      29, 14, 7, 4, 2, 1, 0, 0
   };

   localparam int INV_GAIN_TAB [TAB_LEN] = '{
      46341, 41449, 40211, 39901, 39823, 39803, 39799, 39797,
      39797, 39797, 39797, 39797, 39797, 39797, 39797, 39797,
      39797, 39797, 39797, 39797, 39797, 39797, 39797, 39797
   };

   typedef struct packed {
      logic signed [DATA_W-1:0] m00;
      logic signed [DATA_W-1:0] m01;
      logic signed [DATA_W-1:0] m02;
      logic signed [DATA_W-1:0] m10;
      logic signed [DATA_W-1:0] m11;
      logic signed [DATA_W-1:0] m12;
      logic signed [DATA_W-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [15:0] roll_deg;
      logic signed [15:0] pitch_deg;
      logic signed [15:0] yaw_deg;
      logic               gimbal_case;
   } rsp_type;

   function automatic logic signed [CW-1:0] scale(input logic signed [DATA_W-1:0] m);
      logic signed [CW-1:0] t;
      t = CW'(m);
      return t <<< PRE_SHIFT;
   endfunction

   function automatic logic [DATA_W:0] mag(input logic signed [DATA_W-1:0] m);
      logic signed [DATA_W:0] t;
      t = (DATA_W+1)'(m);
      return t[DATA_W] ? (DATA_W+1)'(-t) : (DATA_W+1)'(t);
   endfunction

   function automatic logic signed [15:0] to_out(input logic signed [ZW-1:0] z);
      logic signed [ZW:0] r;
      logic signed [ZW:0] sum;
      sum = (ZW+1)'(z) + (ZW+1)'(128);
      r = sum >>> 8;
      if (r > (ZW+1)'(OUT_LIMIT)) begin
         r = (ZW+1)'(OUT_LIMIT);
      end else if (r < -(ZW+1)'(OUT_LIMIT)) begin
         r = -(ZW+1)'(OUT_LIMIT);
      end
      return r[15:0];
   endfunction

endpackage

### rtl/rm2e_cordic.sv
module rm2e_cordic import rm2e_pkg::*; #(
   parameter int STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [CW-1:0] in_y,
   input  logic signed [CW-1:0] in_x,
   output logic                 out_valid,
   output logic signed [ZW-1:0] out_z,
   output logic signed [CW-1:0] out_len
);

   logic signed [CW-1:0] x_ff [0:STEPS];
   logic signed [CW-1:0] y_ff [0:STEPS];
   logic signed [ZW-1:0] z_ff [0:STEPS];
   logic                 zero_ff [0:STEPS];
   logic                 valid_ff [0:STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= STEPS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 0; i < STEPS; i++) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end
   end

   // quadrant fold then micro-rotations, one per stage
   always_ff @(posedge clock) begin
      zero_ff[0] <= (in_x == '0) && (in_y == '0);
      if (in_x[CW-1]) begin
         x_ff[0] <= -in_x;
         y_ff[0] <= -in_y;
         z_ff[0] <= in_y[CW-1] ? -ZW'(ANG_180) : ZW'(ANG_180);
      end else begin
         x_ff[0] <= in_x;
         y_ff[0] <= in_y;
         z_ff[0] <= '0;
      end
      for (int i = 0; i < STEPS; i++) begin
         zero_ff[i+1] <= zero_ff[i];
         if (!y_ff[i][CW-1]) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + ZW'(ATAN_TAB[i]);
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - ZW'(ATAN_TAB[i]);
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_z = zero_ff[STEPS] ? '0 : z_ff[STEPS];
   assign out_len = zero_ff[STEPS] ? '0 : x_ff[STEPS];

endmodule

### rtl/rotation_matrix_to_euler_xyz_top.sv
// XYZ Euler angles from seven rotation-matrix entries (Q2.14 signed).
// Request channel: drive req_data and raise start; the request is taken
// at a clock edge where start is high and busy is low. busy stays low, so
// a new request can be given in every cycle.
// Response channel: rsp_valid is high for exactly one cycle with rsp_data
// holding roll, pitch and yaw in 1/128 degree plus the gimbal_case flag.
// The receiver cannot hold responses off; there is nothing to stall.
// The response path runs through the input register, two CORDIC pipelines in
// series (roll then pitch, yaw alongside the first) with the length-scaling
// multiply between them, and the output register. Throughput is one request
// per cycle.
// Threshold register: written through csr_valid/csr_data, csr_ready is
// always high; write it only while no request is in flight.
// Reset (synchronous, active high) clears all valid bits and sets the
// threshold to 1; requests in flight at reset are dropped.
module rotation_matrix_to_euler_xyz_top import rm2e_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [THR_W-1:0] csr_data
);

   localparam int PW = CW + INV_W;
   localparam logic signed [PW-1:0] INV_GAIN = PW'(INV_GAIN_TAB[CORDIC_STEPS-1]);
   localparam logic signed [PW-1:0] HALF = PW'(32768);

   logic [THR_W-1:0] thr_ff;
   logic             v0_ff;
   req_type          m_ff;
   logic             degen;
   logic signed [CW-1:0] a_y, a_x, b_y, b_x;
   logic             a_valid, b_valid, c_valid;
   logic signed [ZW-1:0] a_z, b_z, c_z;
   logic signed [CW-1:0] a_len, b_len, c_len;

   logic             d1_degen_ff [0:CORDIC_STEPS];
   logic signed [DATA_W-1:0] d1_m02_ff [0:CORDIC_STEPS];

   logic             vm_ff, degen_m_ff, vh_ff, degen_h_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [ZW-1:0] za_m_ff, zb_m_ff, za_h_ff, zb_h_ff;
   logic signed [DATA_W-1:0] m02_m_ff, m02_h_ff;
   logic signed [CW-1:0] h_ff;
   logic signed [PW-1:0] h_sum;

   logic             d2_degen_ff [0:CORDIC_STEPS];
   logic signed [ZW-1:0] d2_za_ff [0:CORDIC_STEPS];
   logic signed [ZW-1:0] d2_zb_ff [0:CORDIC_STEPS];

   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(1);
         v0_ff <= 1'b0;
         vm_ff <= 1'b0;
         vh_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            thr_ff <= csr_data;
         end
         v0_ff <= start;
         vm_ff <= a_valid;
         vh_ff <= vm_ff;
         rsp_valid_ff <= c_valid;
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      m_ff <= req_data;
   end

   assign degen = (mag(m_ff.m22) < {2'b00, thr_ff}) && (mag(m_ff.m12) < {2'b00, thr_ff});

   assign a_y = degen ? scale(m_ff.m02) : -scale(m_ff.m12);
   assign a_x = scale(m_ff.m22);
   assign b_y = degen ? scale(m_ff.m10) : -scale(m_ff.m01);
   assign b_x = degen ? scale(m_ff.m11) : scale(m_ff.m00);

   rm2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_a (
      .clock(clock), .reset(reset), .in_valid(v0_ff), .in_y(a_y), .in_x(a_x),
      .out_valid(a_valid), .out_z(a_z), .out_len(a_len)
   );

   rm2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_b (
      .clock(clock), .reset(reset), .in_valid(v0_ff), .in_y(b_y), .in_x(b_x),
      .out_valid(b_valid), .out_z(b_z), .out_len(b_len)
   );

   always_ff @(posedge clock) begin
      d1_degen_ff[0] <= degen;
      d1_m02_ff[0] <= m_ff.m02;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         d1_degen_ff[i+1] <= d1_degen_ff[i];
         d1_m02_ff[i+1] <= d1_m02_ff[i];
      end
   end

   // length scaling by inverse gain
   assign h_sum = prod_ff + HALF;

   always_ff @(posedge clock) begin
      prod_ff <= PW'(a_len) * INV_GAIN;
      za_m_ff <= a_z;
      zb_m_ff <= b_z;
      degen_m_ff <= d1_degen_ff[CORDIC_STEPS];
      m02_m_ff <= d1_m02_ff[CORDIC_STEPS];
      h_ff <= CW'(h_sum >>> 16);
      za_h_ff <= za_m_ff;
      zb_h_ff <= zb_m_ff;
      degen_h_ff <= degen_m_ff;
      m02_h_ff <= m02_m_ff;
   end

   rm2e_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_c (
      .clock(clock), .reset(reset), .in_valid(vh_ff), .in_y(scale(m02_h_ff)),
      .in_x(h_ff), .out_valid(c_valid), .out_z(c_z), .out_len(c_len)
   );

   always_ff @(posedge clock) begin
      d2_degen_ff[0] <= degen_h_ff;
      d2_za_ff[0] <= za_h_ff;
      d2_zb_ff[0] <= zb_h_ff;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         d2_degen_ff[i+1] <= d2_degen_ff[i];
         d2_za_ff[i+1] <= d2_za_ff[i];
         d2_zb_ff[i+1] <= d2_zb_ff[i];
      end
   end

   always_comb begin
      rsp_in.gimbal_case = d2_degen_ff[CORDIC_STEPS];
      rsp_in.yaw_deg = to_out(d2_zb_ff[CORDIC_STEPS]);
      if (d2_degen_ff[CORDIC_STEPS]) begin
         rsp_in.roll_deg = '0;
         rsp_in.pitch_deg = to_out(d2_za_ff[CORDIC_STEPS]);
      end else begin
         rsp_in.roll_deg = to_out(d2_za_ff[CORDIC_STEPS]);
         rsp_in.pitch_deg = to_out(c_z);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
